// ===== hdl/wpa_pkg.sv =====
// wpa_pkg: shared types and constants for the windowed presence alarm
// used by wpa_ctrl, wpa_dp and windowed_presence_alarm; depends on nothing

package wpa_pkg;

	// widths fixed by the item format
	localparam int TS_W      = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	// default depth of the closed span ring
	localparam int MAX_SPANS_DEF = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd2;

	// configuration reset values
	localparam logic [CFG_W-1:0] THRESHOLD_RST = 32'd60;
	localparam logic [CFG_W-1:0] WINDOW_RST    = 32'd300;
	localparam logic [CFG_W-1:0] COOLDOWN_RST  = 32'd10;

	// one closed span as held in the ring
	typedef struct packed {
		logic [TS_W-1:0] hi;
		logic [TS_W-1:0] lo;
	} span_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;   // take the input item
		logic pre;       // streak, open span, push and quiet bookkeeping
		logic rd;        // issue one ring read of the window walk
		logic open;      // add open span, clip it, commit kept count
		logic latch;     // compare total against threshold
		logic done;      // clear check and load the result register
	} wpa_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rd_left;   // ring entries still to be read
		logic pipe_busy; // walk pipeline still holds entries
		logic out_free;  // result register can take a new result
	} wpa_sts_t;

endpackage

// ===== hdl/wpa_ctrl.sv =====
// wpa_ctrl: sequencing state machine for one sample
// depends on wpa_pkg for the command and status structs

module wpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  wpa_pkg::wpa_sts_t sts,
	output logic              in_ready,
	output wpa_pkg::wpa_cmd_t cmd
);
	import wpa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_SCAN,
		ST_OPEN,
		ST_LATCH,
		ST_DONE
	} state_t;

	state_t state_q;

	// command decode
	always_comb begin
		cmd         = '0;
		in_ready    = (state_q == ST_IDLE);
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.pre     = (state_q == ST_PRE);
		cmd.rd      = (state_q == ST_SCAN) && sts.rd_left;
		cmd.open    = (state_q == ST_OPEN);
		cmd.latch   = (state_q == ST_LATCH);
		cmd.done    = (state_q == ST_DONE) && sts.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_PRE;
				end
				ST_PRE: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!sts.rd_left && !sts.pipe_busy) state_q <= ST_OPEN;
				end
				ST_OPEN: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/wpa_dp.sv =====
// wpa_dp: datapath with config registers, span ring memory, window walk,
// alarm latch and result register; depends on wpa_pkg

module wpa_dp #(
	parameter int MAX_SPANS = wpa_pkg::MAX_SPANS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wpa_pkg::wpa_cmd_t             cmd,
	output wpa_pkg::wpa_sts_t             sts,
	input  logic [wpa_pkg::TS_W-1:0]      timestamp,
	input  logic                          visible,
	input  logic                          cfg_we,
	input  logic [wpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wpa_pkg::CFG_W-1:0]     cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wpa_pkg::TS_W-1:0]      windowed_total,
	output logic                          latched,
	output logic                          active
);
	import wpa_pkg::*;

	localparam int IDX_W = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
	localparam int CNT_W = $clog2(MAX_SPANS + 1);
	localparam int PW    = CNT_W + 1;
	localparam int SW    = TS_W + 2;     // signed time differences
	localparam int DW    = TS_W + 1;     // one span contribution
	localparam int ACC_W = SW + CNT_W;   // sum of all contributions

	// configuration registers
	logic [CFG_W-1:0] thr_q, win_q, cool_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RST;
			win_q  <= WINDOW_RST;
			cool_q <= COOLDOWN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q  <= cfg_data;
				REG_WINDOW:    win_q  <= cfg_data;
				REG_COOLDOWN:  cool_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured sample
	logic [TS_W-1:0] ts_q;
	logic            vis_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ts_q  <= timestamp;
			vis_q <= visible;
		end
	end

	// tracker state
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] head_q;
	logic             open_q;
	logic [TS_W-1:0]  ob_q;
	logic [TS_W-1:0]  quiet_q;
	logic             latch_q;
	logic [TS_W-1:0]  streak_q;
	logic             sus_q;

	// walk state
	logic [CNT_W-1:0] rd_cnt_q;
	logic [CNT_W-1:0] kept_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [IDX_W-1:0] wr_ptr_q;
	logic [ACC_W-1:0] acc_q;

	// ring memory
	span_t mem_q [MAX_SPANS];
	span_t rd_data_s1;
	logic  rd_vld_s1;

	// window cutoff, signed
	logic signed [SW-1:0] now_s, cutoff;
	logic                 win_on;

	assign now_s  = $signed({2'b00, ts_q});
	assign cutoff = now_s - $signed({2'b00, win_q});
	assign win_on = (win_q != '0);

	// bookkeeping for the new sample
	logic [TS_W-1:0]  streak_nx;
	logic             sus_nx;
	logic             push_en;
	logic             open_nx;
	logic [TS_W-1:0]  ob_nx;
	logic [TS_W-1:0]  quiet_pre;
	logic             ring_full;
	logic [PW-1:0]    psum, pidx;
	logic [IDX_W-1:0] push_idx, head_nx;
	logic [CNT_W-1:0] cnt_nx;

	always_comb begin
		streak_nx = vis_q ? ((streak_q == '0) ? ts_q : streak_q) : '0;
		sus_nx    = vis_q && (streak_nx != '0) && (ts_q > streak_nx);
		push_en   = 1'b0;
		open_nx   = open_q;
		ob_nx     = ob_q;
		quiet_pre = quiet_q;
		if (open_q && !vis_q) begin
			push_en = (ts_q > ob_q);
			open_nx = 1'b0;
			ob_nx   = '0;
		end else if (!open_q && vis_q) begin
			open_nx = 1'b1;
			ob_nx   = ts_q;
			if (sus_nx) quiet_pre = '0;
		end else if (open_q && vis_q && sus_nx) begin
			quiet_pre = '0;
		end
		if (!vis_q && latch_q && quiet_pre == '0) quiet_pre = ts_q;
	end

	// push slot: overwrite oldest when full, else append after the last
	always_comb begin
		ring_full = (cnt_q == CNT_W'(MAX_SPANS));
		psum      = PW'(head_q) + PW'(cnt_q);
		pidx      = (psum >= PW'(MAX_SPANS)) ? (psum - PW'(MAX_SPANS)) : psum;
		head_nx   = head_q;
		cnt_nx    = cnt_q;
		if (ring_full) begin
			push_idx = head_q;
			if (push_en) begin
				head_nx = (head_q == IDX_W'(MAX_SPANS - 1)) ? '0 : head_q + 1'b1;
			end
		end else begin
			push_idx = pidx[IDX_W-1:0];
			if (push_en) cnt_nx = cnt_q + 1'b1;
		end
	end

	// per entry clip and contribution, from the read stage
	logic signed [SW-1:0] e_lo, e_hi, e_a, e_diff;
	logic                 e_keep;
	logic [DW-1:0]        e_contrib;

	always_comb begin
		e_lo      = $signed({2'b00, rd_data_s1.lo});
		e_hi      = $signed({2'b00, rd_data_s1.hi});
		e_a       = (e_lo > cutoff) ? e_lo : cutoff;
		e_diff    = e_hi - e_a;
		e_contrib = (e_hi > e_a) ? e_diff[DW-1:0] : '0;
		e_keep    = win_on && (e_hi > cutoff);
	end

	// second walk stage
	logic          vld_s2, keep_s2;
	logic [DW-1:0] contrib_s2;
	span_t         span_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			vld_s2    <= rd_vld_s1;
			rd_vld_s1 <= cmd.rd;
		end
	end

	always_ff @(posedge clk) begin
		keep_s2    <= e_keep;
		contrib_s2 <= e_contrib;
		span_s2.hi <= rd_data_s1.hi;
		span_s2.lo <= e_a[TS_W-1:0];
	end

	// memory write port: push or compaction, never both
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	span_t            mem_wd;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_ptr_q;
		mem_wd = span_s2;
		if (cmd.pre) begin
			mem_we    = push_en;
			mem_wa    = push_idx;
			mem_wd.lo = ob_q;
			mem_wd.hi = ts_q;
		end else if (vld_s2 && keep_s2) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_data_s1 <= mem_q[rd_ptr_q];
	end

	// open span contribution
	logic signed [SW-1:0] ob_s, o_a, o_diff;
	logic [DW-1:0]        o_contrib;

	always_comb begin
		ob_s      = $signed({2'b00, ob_q});
		o_a       = (ob_s > cutoff) ? ob_s : cutoff;
		o_diff    = now_s - o_a;
		o_contrib = (open_q && now_s > o_a) ? o_diff[DW-1:0] : '0;
	end

	// cooldown compare
	logic signed [SW-1:0] q_diff;
	logic                 q_ge, q_clear, latch_out, act_out, above;
	logic [TS_W-1:0]      total_sat;

	always_comb begin
		q_diff    = now_s - $signed({2'b00, quiet_q});
		q_ge      = (q_diff >= $signed({2'b00, cool_q}));
		q_clear   = latch_q && !vis_q && (quiet_q != '0) && q_ge;
		latch_out = latch_q && !q_clear;
		act_out   = latch_out && ((quiet_q == '0) || !q_ge);
		above     = (acc_q > {{(ACC_W-CFG_W){1'b0}}, thr_q});
		total_sat = (|acc_q[ACC_W-1:TS_W]) ? '1 : acc_q[TS_W-1:0];
	end

	// tracker and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			head_q   <= '0;
			open_q   <= 1'b0;
			ob_q     <= '0;
			quiet_q  <= '0;
			latch_q  <= 1'b0;
			streak_q <= '0;
			sus_q    <= 1'b0;
			rd_cnt_q <= '0;
			kept_q   <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			acc_q    <= '0;
		end else begin
			if (cmd.pre) begin
				streak_q <= streak_nx;
				sus_q    <= sus_nx;
				open_q   <= open_nx;
				ob_q     <= ob_nx;
				quiet_q  <= quiet_pre;
				head_q   <= head_nx;
				cnt_q    <= cnt_nx;
				rd_cnt_q <= '0;
				kept_q   <= '0;
				rd_ptr_q <= head_nx;
				wr_ptr_q <= head_nx;
				acc_q    <= '0;
			end
			if (cmd.rd) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
				rd_ptr_q <= (rd_ptr_q == IDX_W'(MAX_SPANS - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (vld_s2) begin
				acc_q <= acc_q + {{(ACC_W-DW){1'b0}}, contrib_s2};
				if (keep_s2) begin
					kept_q   <= kept_q + 1'b1;
					wr_ptr_q <= (wr_ptr_q == IDX_W'(MAX_SPANS - 1)) ? '0 : wr_ptr_q + 1'b1;
				end
			end
			if (cmd.open) begin
				acc_q <= acc_q + {{(ACC_W-DW){1'b0}}, o_contrib};
				if (win_on) begin
					cnt_q <= kept_q;
					if (open_q && ob_s < cutoff) ob_q <= cutoff[TS_W-1:0];
				end
			end
			if (cmd.latch && above) begin
				latch_q <= 1'b1;
				if (sus_q) quiet_q <= '0;
				else if (!vis_q && quiet_q == '0) quiet_q <= ts_q;
			end
			if (cmd.done && q_clear) begin
				latch_q <= 1'b0;
				quiet_q <= '0;
			end
		end
	end

	// result register
	logic            out_valid_q;
	logic [TS_W-1:0] total_q;
	logic            latched_q, active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			total_q   <= total_sat;
			latched_q <= latch_out;
			active_q  <= act_out;
		end
	end

	assign out_valid      = out_valid_q;
	assign windowed_total = total_q;
	assign latched        = latched_q;
	assign active         = active_q;

	// status to controller
	assign sts.rd_left   = (rd_cnt_q != cnt_q);
	assign sts.pipe_busy = rd_vld_s1 | vld_s2;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ===== hdl/windowed_presence_alarm.sv =====
// windowed_presence_alarm: top level, controller plus datapath
// depends on wpa_pkg, wpa_ctrl and wpa_dp
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   in       | in_valid / in_ready  | timestamp, visible
//   out      | out_valid / out_ready| windowed_total, latched, active
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// one sample passes from its transfer through the bookkeeping step, the walk
// over the n closed spans held (at most MAX_SPANS), the open span step and the
// threshold compare to the load of its result; the walk reads the span memory,
// which has one write port and one read port, one entry per cycle.
// a result waits in its own register, so the next sample transfers while it
// is held; a sample that finishes before that result leaves stalls there.
// reset needs no clearing pass: the span memory is read only below its count.

module windowed_presence_alarm #(
	parameter int MAX_SPANS = wpa_pkg::MAX_SPANS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wpa_pkg::TS_W-1:0]      timestamp,
	input  logic                          visible,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wpa_pkg::TS_W-1:0]      windowed_total,
	output logic                          latched,
	output logic                          active,
	input  logic                          cfg_we,
	input  logic [wpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wpa_pkg::CFG_W-1:0]     cfg_data
);
	import wpa_pkg::*;

	wpa_cmd_t cmd;
	wpa_sts_t sts;

	// sequencer
	wpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// datapath
	wpa_dp #(
		.MAX_SPANS (MAX_SPANS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.timestamp      (timestamp),
		.visible        (visible),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.windowed_total (windowed_total),
		.latched        (latched),
		.active         (active)
	);

endmodule

// ===== dv/windowed_presence_alarm_test.sv =====
// windowed_presence_alarm_test: self-checking bench for windowed_presence_alarm
// drives timestamped presence samples, predicts totals, latch and active flag
// depends on wpa_pkg and windowed_presence_alarm

module windowed_presence_alarm_test;
	import wpa_pkg::*;

	localparam int SPAN_DEPTH   = MAX_SPANS_DEF;
	localparam int RESET_CYCLES = 5;
	localparam int DIR_ROWS     = 32;
	localparam int RAND_PHASES  = 11;
	localparam int PHASE_ITEMS  = 150;
	localparam int IDLE_SETTLE  = 4;
	localparam int END_SETTLE   = 3 * (SPAN_DEPTH + 7);
	localparam int HOLD_AFTER   = 250;
	localparam int LONG_HOLD    = 600;
	localparam int STALL_LIMIT  = 5000;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint SECS_MAX = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [TS_W-1:0] ts;
		logic            vis;
	} sample_t;

	typedef struct packed {
		logic [TS_W-1:0] total;
		logic            latched;
		logic            active;
	} alarm_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// one directed step: a sample (idx unused) or a register write (vis unused)
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     word;
		logic                 vis;
		logic                 typed;
		alarm_result_t        want;
	} dir_row_t;

	localparam alarm_result_t NO_RESULT = '0;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [TS_W-1:0]      timestamp = '0;
	logic                 visible   = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [TS_W-1:0]      windowed_total;
	logic                 latched;
	logic                 active;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_THRESHOLD;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// predicted block state and settings
	logic [CFG_W-1:0] cfg_threshold, cfg_window, cfg_cooldown;
	span_t            span_ring [SPAN_DEPTH];
	int unsigned      ring_count, ring_head;
	bit               run_open, alarm_set;
	logic [TS_W-1:0]  run_begin, quiet_mark, streak_mark;

	alarm_result_t expected_q [$];
	int unsigned   errors = 0;
	int unsigned   results_seen = 0;
	bit            sender_steady = 1'b0;
	dir_row_t      dir_rows [DIR_ROWS];

	windowed_presence_alarm #(.MAX_SPANS(SPAN_DEPTH)) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.timestamp      (timestamp),
		.visible        (visible),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.windowed_total (windowed_total),
		.latched        (latched),
		.active         (active),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint as_secs(logic [TS_W-1:0] v);
		return longint'({32'd0, v});
	endfunction

	function automatic void clear_model();
		cfg_threshold = THRESHOLD_RST;
		cfg_window    = WINDOW_RST;
		cfg_cooldown  = COOLDOWN_RST;
		ring_count    = 0;
		ring_head     = 0;
		run_open      = 1'b0;
		run_begin     = '0;
		quiet_mark    = '0;
		alarm_set     = 1'b0;
		streak_mark   = '0;
	endfunction

	// advances the predicted state by one sample and returns its result
	function automatic alarm_result_t predict_alarm(sample_t smp);
		longint        now, cutoff, lo, hi, a, sum;
		bit            sustained;
		int unsigned   k, kept, slot;
		alarm_result_t res;
		now = as_secs(smp.ts);

		// visibility streak, zero leaves it unset
		if (smp.vis) begin
			if (streak_mark == 0) streak_mark = smp.ts;
		end else begin
			streak_mark = '0;
		end
		sustained = smp.vis && streak_mark != 0 && (now - as_secs(streak_mark)) >= 1;

		// open span bookkeeping, closing pushes into the ring
		if (run_open && !smp.vis) begin
			if (now > as_secs(run_begin)) begin
				if (ring_count >= SPAN_DEPTH) begin
					span_ring[ring_head] = {smp.ts, run_begin};
					ring_head = (ring_head + 1) % SPAN_DEPTH;
				end else begin
					span_ring[(ring_head + ring_count) % SPAN_DEPTH] = {smp.ts, run_begin};
					ring_count++;
				end
			end
			run_open  = 1'b0;
			run_begin = '0;
		end else if (!run_open && smp.vis) begin
			run_open  = 1'b1;
			run_begin = smp.ts;
			if (sustained) quiet_mark = '0;
		end else if (run_open && smp.vis && sustained) begin
			quiet_mark = '0;
		end
		if (!smp.vis && alarm_set && quiet_mark == 0) quiet_mark = smp.ts;

		// drop spans that left the window and clip the rest
		cutoff = now - as_secs(cfg_window);
		if (cfg_window != 0) begin
			kept = 0;
			for (k = 0; k < ring_count; k++) begin
				slot = (ring_head + k) % SPAN_DEPTH;
				lo = as_secs(span_ring[slot].lo);
				hi = as_secs(span_ring[slot].hi);
				if (hi > cutoff) begin
					if (lo < cutoff) lo = cutoff;
					span_ring[(ring_head + kept) % SPAN_DEPTH] = {hi[31:0], lo[31:0]};
					kept++;
				end
			end
			ring_count = kept;
			if (run_open && as_secs(run_begin) < cutoff) run_begin = cutoff[31:0];
		end

		// visible seconds inside the window
		sum = 0;
		for (k = 0; k < ring_count; k++) begin
			slot = (ring_head + k) % SPAN_DEPTH;
			lo = as_secs(span_ring[slot].lo);
			hi = as_secs(span_ring[slot].hi);
			a = (lo > cutoff) ? lo : cutoff;
			if (hi > a) sum += hi - a;
		end
		if (run_open) begin
			a = (as_secs(run_begin) > cutoff) ? as_secs(run_begin) : cutoff;
			if (now > a) sum += now - a;
		end

		// latch on threshold
		if (sum > as_secs(cfg_threshold)) begin
			alarm_set = 1'b1;
			if (sustained) quiet_mark = '0;
			else if (!smp.vis && quiet_mark == 0) quiet_mark = smp.ts;
		end

		// clear after the cooldown
		if (alarm_set && !smp.vis && quiet_mark != 0 &&
				(now - as_secs(quiet_mark)) >= as_secs(cfg_cooldown)) begin
			alarm_set  = 1'b0;
			quiet_mark = '0;
		end

		if (!alarm_set) res.active = 1'b0;
		else if (quiet_mark == 0) res.active = 1'b1;
		else res.active = (now - as_secs(quiet_mark)) < as_secs(cfg_cooldown);

		if (sum > SECS_MAX) sum = SECS_MAX;
		if (sum < 0) sum = 0;
		res.total   = sum[31:0];
		res.latched = alarm_set;
		return res;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_W-1:0] pick_setting(int unsigned typ_hi);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return $urandom;
			default: return $urandom_range(0, typ_hi);
		endcase
	endfunction

	// register write, block must be idle; cfg_we is lowered by the next sample
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD: cfg_threshold = val;
			REG_WINDOW:    cfg_window    = val;
			REG_COOLDOWN:  cfg_cooldown  = val;
			default: ;
		endcase
	endtask

	// offer one sample, wait for its transfer, queue what it should produce
	task automatic send_sample(sample_t smp, bit typed, alarm_result_t want);
		int unsigned   gap;
		alarm_result_t pred;
		gap = sender_steady ? 0 : idle_gap();
		cfg_we <= 1'b0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		timestamp <= smp.ts;
		visible   <= smp.vis;
		do @(posedge clk); while (!in_ready);
		pred = predict_alarm(smp);
		expected_q.insert(expected_q.size(), typed ? want : pred);
	endtask

	// stop offering and let every queued result come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// stimulus: directed table, then random phases under changing settings
	initial begin : stimulus
		sample_t     smp;
		int unsigned k, phase, run_left, r;
		logic [TS_W-1:0] cursor;
		logic        cur_vis, pending;

		clear_model();
		dir_rows = '{
			// fresh after reset, unset timestamp, latch, cooldown boundary
			'{ROW_SAMPLE, REG_SPARE, 32'd1,   1'b0, 1'b1, '{32'd0,   1'b0, 1'b0}},
			'{ROW_SAMPLE, REG_SPARE, 32'd0,   1'b1, 1'b1, '{32'd0,   1'b0, 1'b0}},
			'{ROW_SAMPLE, REG_SPARE, 32'd100, 1'b1, 1'b1, '{32'd100, 1'b1, 1'b1}},
			'{ROW_SAMPLE, REG_SPARE, 32'd101, 1'b0, 1'b1, '{32'd101, 1'b1, 1'b1}},
			'{ROW_SAMPLE, REG_SPARE, 32'd111, 1'b0, 1'b1, '{32'd101, 1'b0, 1'b0}},
			// sustained visibility restarts the clear timer
			'{ROW_SAMPLE, REG_SPARE, 32'd200, 1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd201, 1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd205, 1'b0, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd210, 1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd211, 1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd211, 1'b0, 1'b0, NO_RESULT},
			// empty span is not stored
			'{ROW_SAMPLE, REG_SPARE, 32'd211, 1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd211, 1'b0, 1'b0, NO_RESULT},
			// time going backward
			'{ROW_SAMPLE, REG_SPARE, 32'd150, 1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd120, 1'b0, 1'b0, NO_RESULT},
			// top of the timestamp range
			'{ROW_SAMPLE, REG_SPARE, '1,      1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, '1,      1'b0, 1'b0, NO_RESULT},
			// widest window, highest threshold and cooldown
			'{ROW_WRITE,  REG_WINDOW,    '1,  1'b0, 1'b0, NO_RESULT},
			'{ROW_WRITE,  REG_THRESHOLD, '1,  1'b0, 1'b0, NO_RESULT},
			'{ROW_WRITE,  REG_COOLDOWN,  '1,  1'b0, 1'b0, NO_RESULT},
			// overlapping full range spans saturate the total
			'{ROW_SAMPLE, REG_SPARE, 32'd1,   1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, '1,      1'b0, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd1,   1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, '1,      1'b0, 1'b0, NO_RESULT},
			// zero window, threshold and cooldown, write to the spare index
			'{ROW_WRITE,  REG_WINDOW,    '0,  1'b0, 1'b0, NO_RESULT},
			'{ROW_WRITE,  REG_THRESHOLD, '0,  1'b0, 1'b0, NO_RESULT},
			'{ROW_WRITE,  REG_COOLDOWN,  '0,  1'b0, 1'b0, NO_RESULT},
			'{ROW_WRITE,  REG_SPARE,     '1,  1'b0, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd7,   1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd9,   1'b1, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd12,  1'b0, 1'b0, NO_RESULT},
			'{ROW_SAMPLE, REG_SPARE, 32'd13,  1'b0, 1'b0, NO_RESULT}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		pending = 1'b0;
		for (k = 0; k < DIR_ROWS; k++) begin
			if (dir_rows[k].kind == ROW_WRITE) begin
				if (pending) wait_drained();
				pending = 1'b0;
				write_reg(dir_rows[k].idx, dir_rows[k].word);
			end else begin
				smp.ts  = dir_rows[k].word;
				smp.vis = dir_rows[k].vis;
				send_sample(smp, dir_rows[k].typed, dir_rows[k].want);
				pending = 1'b1;
			end
		end

		// random phases: mostly runs of visibility over rising time, some noise
		cursor   = 32'd1000;
		cur_vis  = 1'b0;
		run_left = 0;
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			wait_drained();
			if (phase == 0) begin
				write_reg(REG_THRESHOLD, THRESHOLD_RST);
				write_reg(REG_WINDOW, WINDOW_RST);
				write_reg(REG_COOLDOWN, COOLDOWN_RST);
			end else begin
				write_reg(REG_THRESHOLD, pick_setting(200));
				write_reg(REG_WINDOW, pick_setting(600));
				write_reg(REG_COOLDOWN, pick_setting(40));
				if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
			end
			sender_steady = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 86) begin
					if (run_left == 0) begin
						cur_vis  = !cur_vis;
						run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
							: $urandom_range(1, 6);
					end
					run_left--;
					cursor += ($urandom_range(0, 49) == 0) ? $urandom_range(50, 2000)
						: $urandom_range(0, 4);
					if (cursor == 0) cursor = 1;
					smp.ts  = cursor;
					smp.vis = cur_vis;
				end else if (r < 90) begin
					smp.ts  = $urandom;
					smp.vis = 1'($urandom_range(0, 1));
				end else if (r < 93) begin
					smp.ts  = '0;
					smp.vis = 1'($urandom_range(0, 1));
				end else if (r < 97) begin
					smp.ts  = cursor - $urandom_range(1, 60);
					smp.vis = 1'($urandom_range(0, 1));
				end else begin
					cursor  = $urandom;
					smp.ts  = cursor;
					smp.vis = cur_vis;
				end
				send_sample(smp, 1'b0, NO_RESULT);
			end
		end

		wait_drained();
		repeat (END_SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("windowed_presence_alarm_test: clean");
		end else begin
			$display("windowed_presence_alarm_test: errors");
		end
		$finish;
	end

	// result side ready: bursts and stalls, one long hold-off to back up the block
	initial begin : result_sink
		int unsigned run;
		bit          stretched;
		stretched = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!stretched && results_seen >= HOLD_AFTER) begin
				stretched = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			run = idle_gap();
			if (run != 0) begin
				out_ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		alarm_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got.total   = windowed_total;
			got.latched = latched;
			got.active  = active;
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result total %0d latched %0b active %0b",
					$time, got.total, got.latched, got.active);
			end else begin
				want = expected_q.pop_front();
				if (got.total !== want.total) begin
					errors++;
					$display("%0t: windowed_total expected %0d got %0d",
						$time, want.total, got.total);
				end
				if (got.latched !== want.latched) begin
					errors++;
					$display("%0t: latched expected %0b got %0b",
						$time, want.latched, got.latched);
				end
				if (got.active !== want.active) begin
					errors++;
					$display("%0t: active expected %0b got %0b",
						$time, want.active, got.active);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("windowed_presence_alarm_test: errors");
		$finish;
	end

endmodule
